// ===== sv/mrkx_pkg.sv =====
// mrkx_pkg: shared types and constants for the masked range keystream XOR block.
// Holds the payload structs, the front-to-back transaction struct and SHA-256 tables.
// No dependencies.
package mrkx_pkg;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  entry_index;
        logic [63:0] entry_offset;
        logic [31:0] entry_length;
        logic [7:0]  data_byte;
        logic [63:0] byte_offset;
        logic        first_of_read;
        logic        last_of_read;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       covered;
        logic       last_out;
    } t_out_item;

    // classified data byte handed from the front part to the back part
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [63:0] byte_offset;
        logic        first_of_read;
        logic        last_of_read;
        logic        covered;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    localparam logic [255:0] KEY_WORDS =
        256'h66697865645f6b65795f666f725f6d61736b696e675f737472696e67735f6b65;

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] sha_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/mrkx_ram.sv =====
// mrkx_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrkx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/mrkx_front.sv =====
// mrkx_front: accepts transactions, writes range entries, and classifies data bytes
// by scanning the range table one entry per cycle. Depends on mrkx_pkg, mrkx_ram.
module mrkx_front #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [6:0]         i_entry_count,
    input  logic               i_push,
    input  mrkx_pkg::t_in_item i_item,
    output logic               o_full,
    output logic               o_job_valid,
    output mrkx_pkg::t_job     o_job,
    input  logic               i_job_ready
);
    import mrkx_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW = 96;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]   r_state, n_state;
    t_in_item     r_item;
    logic [CW:0]  r_idx, n_idx;
    logic         r_rd_ok;
    logic         r_hit, n_hit;
    logic [CW:0]  w_limit;
    logic         w_accept, w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [RW-1:0] w_rdata;
    logic [63:0]  w_start, w_diff;
    logic [31:0]  w_len;

    assign w_limit = ({{(CW+1){1'b0}}, i_entry_count} > (CW+1+7)'(MAX_ENTRIES))
                     ? (CW+1)'(MAX_ENTRIES) : (CW+1)'(i_entry_count);
    assign o_full   = (r_state != ST_IDLE);
    assign w_accept = i_push && !o_full;
    assign w_we     = w_accept && (i_item.req_type == REQ_LOAD)
                      && ({{(AW+7){1'b0}}, i_item.entry_index} < (AW+13)'(MAX_ENTRIES));
    assign w_waddr  = AW'(i_item.entry_index);
    assign w_raddr  = r_idx[AW-1:0];

    mrkx_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata({i_item.entry_offset, i_item.entry_length}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_start = w_rdata[RW-1:32];
    assign w_len   = w_rdata[31:0];
    assign w_diff  = r_item.byte_offset - w_start;

    assign o_job_valid = (r_state == ST_DONE);
    assign o_job = '{data_byte: r_item.data_byte, byte_offset: r_item.byte_offset,
                     first_of_read: r_item.first_of_read, last_of_read: r_item.last_of_read,
                     covered: r_hit};

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_hit   = r_hit;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_item.req_type == REQ_DATA) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                end
            end
            ST_SCAN: begin
                if (r_rd_ok && r_item.byte_offset >= w_start && w_diff < {32'd0, w_len}) begin
                    n_hit = 1'b1;
                end
                if (r_idx >= w_limit) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_job_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            // read data valid when the previous address lay below the limit
            r_rd_ok <= (r_state == ST_SCAN) && (r_idx < w_limit);
        end
        r_idx <= n_idx;
        r_hit <= n_hit;
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    a_job_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> o_full)
        else $error("job offered while front idle");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> (r_state != ST_IDLE))
        else $error("scan left without handoff");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= w_limit))
        else $error("scan index beyond limit");
endmodule

// ===== sv/mrkx_fifo.sv =====
// mrkx_fifo: two-entry queue between the classifier and the keystream engine.
// Depends on mrkx_pkg.
module mrkx_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mrkx_pkg::t_job i_data,
    output logic           o_ready,
    output logic           o_valid,
    output mrkx_pkg::t_job o_data,
    input  logic           i_ready
);
    import mrkx_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_ptr_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt == 2'd0) || (r_cnt == 2'd2)) |-> (r_wp == r_rp))
        else $error("queue pointers inconsistent");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count did not advance");
endmodule

// ===== sv/mrkx_back.sv =====
// mrkx_back: segment tracking, SHA-256 keystream (one round per cycle) and XOR,
// with a two-entry result queue. Depends on mrkx_pkg.
module mrkx_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  mrkx_pkg::t_job      i_job,
    output logic                o_job_ready,
    output logic                o_empty,
    output mrkx_pkg::t_out_item o_item,
    input  logic                i_pop
);
    import mrkx_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HASH = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]    r_state;
    logic          r_in_seg;
    logic [63:0]   r_seg_start;
    logic [36:0]   r_ks;
    logic [255:0]  r_digest;
    t_job          r_job;
    logic [5:0]    r_rnd;
    logic [511:0]  r_w;
    logic [31:0]   r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    t_out_item     r_q [2];
    logic          r_qw, r_qr;
    logic [1:0]    r_qcnt;

    logic          w_start_seg, w_in_seg_eff;
    logic [63:0]   w_seg;
    logic [36:0]   w_k;
    logic [511:0]  w_blk;
    logic [31:0]   w_w0, w_w1, w_w9, w_w14, w_s0, w_s1, w_wn;
    logic [31:0]   w_t1, w_t2;
    logic [7:0]    w_ks_byte;
    logic          w_push, w_pop, w_take;

    assign w_in_seg_eff = r_in_seg && !i_job.first_of_read;
    assign w_start_seg  = !w_in_seg_eff;
    assign w_seg        = w_start_seg ? i_job.byte_offset : r_seg_start;
    assign w_k          = w_start_seg ? 37'd0 : r_ks;
    assign w_blk        = {KEY_WORDS, w_seg, w_k[36:5], 32'h80000000,
                           64'd0, 32'd0, 32'h00000160};

    assign w_w0  = r_w[511:480];
    assign w_w1  = r_w[479:448];
    assign w_w9  = r_w[223:192];
    assign w_w14 = r_w[63:32];
    assign w_s0  = rotr(w_w1, 7) ^ rotr(w_w1, 18) ^ (w_w1 >> 3);
    assign w_s1  = rotr(w_w14, 17) ^ rotr(w_w14, 19) ^ (w_w14 >> 10);
    assign w_wn  = w_w0 + w_s0 + w_w9 + w_s1;
    assign w_t1  = r_h + (rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25))
                   + ((r_e & r_f) ^ (~r_e & r_g)) + sha_k(r_rnd) + w_w0;
    assign w_t2  = (rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22))
                   + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    assign w_ks_byte = r_digest[255 - 8 * r_ks[4:0] -: 8];

    assign o_job_ready = (r_state == ST_IDLE);
    assign w_take      = i_job_valid && o_job_ready;
    assign w_push      = (r_state == ST_EMIT) && (r_qcnt != 2'd2);
    assign o_empty     = (r_qcnt == 2'd0);
    assign o_item      = r_q[r_qr];
    assign w_pop       = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_seg    <= 1'b0;
            r_seg_start <= '0;
            r_ks        <= '0;
            r_qw        <= 1'b0;
            r_qr        <= 1'b0;
            r_qcnt      <= 2'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_job <= i_job;
                        if (i_job.covered) begin
                            r_in_seg    <= 1'b1;
                            r_seg_start <= w_seg;
                            r_ks        <= w_k;
                            if (w_k[4:0] == 5'd0) begin
                                r_state <= ST_HASH;
                                r_w     <= w_blk;
                                r_rnd   <= 6'd0;
                                {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= H_INIT;
                            end else begin
                                r_state <= ST_EMIT;
                            end
                        end else begin
                            r_in_seg <= 1'b0;
                            r_state  <= ST_EMIT;
                        end
                    end
                end
                ST_HASH: begin
                    r_w   <= {r_w[479:0], w_wn};
                    r_h   <= r_g;
                    r_g   <= r_f;
                    r_f   <= r_e;
                    r_e   <= r_d + w_t1;
                    r_d   <= r_c;
                    r_c   <= r_b;
                    r_b   <= r_a;
                    r_a   <= w_t1 + w_t2;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state  <= ST_EMIT;
                        r_digest <= {H_INIT[255:224] + w_t1 + w_t2, H_INIT[223:192] + r_a,
                                     H_INIT[191:160] + r_b, H_INIT[159:128] + r_c,
                                     H_INIT[127:96] + r_d + w_t1, H_INIT[95:64] + r_e,
                                     H_INIT[63:32] + r_f, H_INIT[31:0] + r_g};
                    end
                end
                ST_EMIT: begin
                    if (w_push) begin
                        r_q[r_qw] <= '{
                            out_byte: r_job.covered ? (r_job.data_byte ^ w_ks_byte)
                                                    : r_job.data_byte,
                            covered:  r_job.covered,
                            last_out: r_job.last_of_read};
                        r_qw    <= ~r_qw;
                        r_state <= ST_IDLE;
                        if (r_job.covered) r_ks <= r_ks + 37'd1;
                        if (r_job.last_of_read) r_in_seg <= 1'b0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_pop) r_qr <= ~r_qr;
            r_qcnt <= r_qcnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_qcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= 2'd2) else $error("result queue overflow");
    a_hash_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HASH && r_rnd != 6'd63) |=> (r_state == ST_HASH))
        else $error("hash left early");
    a_push_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_state == ST_IDLE)) else $error("emit did not complete");
endmodule

// ===== sv/masked_range_keystream_xor.sv =====
// Masked range keystream XOR, top level. Depends on mrkx_pkg, mrkx_front, mrkx_fifo, mrkx_back.
// A data byte is classified by scanning the range table (one table read per cycle), then
// goes to the back end, which first hashes a new 32-byte keystream block when one is
// needed (one SHA-256 round per cycle). Front and back overlap.
// Synchronous active-low reset clears control and segment state; table is undefined.
module masked_range_keystream_xor #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_wdata,
    input  logic                push,
    output logic                full,
    input  mrkx_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output mrkx_pkg::t_out_item o_item
);
    import mrkx_pkg::*;

    logic [6:0] r_entry_count;
    logic       w_fj_valid, w_fj_ready, w_bj_valid, w_bj_ready;
    t_job       w_fj, w_bj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    mrkx_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_entry_count(r_entry_count),
        .i_push(push), .i_item(i_item), .o_full(full),
        .o_job_valid(w_fj_valid), .o_job(w_fj), .i_job_ready(w_fj_ready)
    );

    mrkx_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fj_valid), .i_data(w_fj), .o_ready(w_fj_ready),
        .o_valid(w_bj_valid), .o_data(w_bj), .i_ready(w_bj_ready)
    );

    mrkx_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_bj_valid), .i_job(w_bj), .o_job_ready(w_bj_ready),
        .o_empty(empty), .o_item(o_item), .i_pop(pop)
    );
endmodule
